// ===== src/sbpc_pkg.sv =====
// Shared types and constants of the SPI bit-bang pattern codec.
`timescale 1ns / 1ps
package sbpc_pkg;

  localparam int MAX_BURST  = 64;
  localparam int TXC_W      = $clog2(MAX_BURST + 1);
  localparam int RXP_W      = $clog2(16 * MAX_BURST + 3);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    REG_MOSI   = 2'd0,
    REG_CLOCK  = 2'd1,
    REG_SELECT = 2'd2,
    REG_MISO   = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  localparam logic KIND_PIN  = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  typedef struct packed {
    logic [7:0] mosi;
    logic [7:0] clk;
    logic [7:0] sel;
    logic [7:0] miso;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{mosi: 8'd2, clk: 8'd1, sel: 8'd8, miso: 8'd4};

  typedef struct packed {
    logic       dec;
    logic       opn;
    logic       dat;
    logic       lst;
    logic [7:0] val;
  } cmd_t;

endpackage

// ===== src/spi_bitbang_pattern_codec.sv =====
// Top level of the SPI mode-0 bit-bang pattern codec.
//
// Input stream in_*: one word per encode byte or per decode pin sample.
//   in_tuser selects encode (0) or decode (1); in_tlast ends an encode burst.
// Output stream out_*: pin samples (out_tuser 0) or received bytes
//   (out_tuser 1); out_tlast marks the last word caused by one input word.
// Config port cfg_*: mask registers; user writes only while idle (unchecked).
// The first output word of an input word passes the command queue, the
//   back-end command registers and the output register in that order.
// Throughput: the back end emits one output word per cycle while the
//   receiver takes them; an encode byte yields 16 pin words (17 with the
//   burst opening sample, 18 with the closing pair, 19 with both).
// A four-entry command queue sits between the input side and the sample
//   generator; in_tready drops only when that queue is full.
// Reset clears the burst counters, the queue and the output valid flag and
//   reloads the mask registers with their defaults.
// When the receiver stalls, the output word holds and the queue keeps
//   absorbing input words until full.
`timescale 1ns / 1ps
module spi_bitbang_pattern_codec import sbpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data, [8] first, [15:9] zero
  input  logic        in_tuser,   // [0] operation
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] pins, [15:8] rx_byte
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  cfg_t cfg_r, cfg_nxt;
  logic q_full, q_push, q_pop, q_valid;
  cmd_t q_wr, q_rd;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_MOSI:   cfg_nxt.mosi = cfg_wdata;
        REG_CLOCK:  cfg_nxt.clk  = cfg_wdata;
        REG_SELECT: cfg_nxt.sel  = cfg_wdata;
        REG_MISO:   cfg_nxt.miso = cfg_wdata;
        default:    cfg_nxt      = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sbpc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .op       (in_tuser),
    .data     (in_tdata[7:0]),
    .first    (in_tdata[8]),
    .last     (in_tlast),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_wr)
  );

  sbpc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_cmd   (q_wr),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_cmd   (q_rd)
  );

  sbpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_cmd     (q_rd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_data  (out_tdata),
    .out_end   (out_tlast)
  );

endmodule

// ===== src/sbpc_front.sv =====
// Front end: accepts input words, tracks burst counters, issues commands.
`timescale 1ns / 1ps
module sbpc_front import sbpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic [7:0] data,
  input  logic       first,
  input  logic       last,
  input  cfg_t       cfg,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  logic [TXC_W-1:0] tx_cnt_r, tx_cnt_nxt;
  logic [RXP_W-1:0] rx_pos_r, rx_pos_nxt;
  logic [7:0]       rx_shift_r, rx_shift_nxt;
  logic [TXC_W-1:0] rx_cnt_r, rx_cnt_nxt;

  logic             acc;
  logic [TXC_W-1:0] tx_cur, rx_cnt_cur;
  logic [RXP_W-1:0] pos_cur, pos_m2;
  logic [7:0]       shift_cur;
  logic             has_res;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    tx_cnt_nxt   = tx_cnt_r;
    rx_pos_nxt   = rx_pos_r;
    rx_shift_nxt = rx_shift_r;
    rx_cnt_nxt   = rx_cnt_r;
    q_cmd        = '0;
    has_res      = 1'b0;
    tx_cur       = first ? '0 : tx_cnt_r;
    pos_cur      = first ? '0 : rx_pos_r;
    shift_cur    = first ? '0 : rx_shift_r;
    rx_cnt_cur   = first ? '0 : rx_cnt_r;
    pos_m2       = pos_cur - RXP_W'(2);
    if (op == OP_ENCODE) begin
      q_cmd.opn = first;
      q_cmd.lst = last;
      q_cmd.val = data;
      q_cmd.dat = tx_cur < TXC_W'(MAX_BURST);
      has_res   = first || last || q_cmd.dat;
      if (acc) begin
        tx_cnt_nxt = q_cmd.dat ? tx_cur + TXC_W'(1) : tx_cur;
      end
    end else begin
      q_cmd.dec = 1'b1;
      if (acc) begin
        rx_pos_nxt   = pos_cur;
        rx_shift_nxt = shift_cur;
        rx_cnt_nxt   = rx_cnt_cur;
      end
      if (rx_cnt_cur < TXC_W'(MAX_BURST)) begin
        if (pos_cur >= RXP_W'(2) && !pos_cur[0]) begin
          q_cmd.val = {shift_cur[6:0], |(data & cfg.miso)};
          if (acc) begin
            rx_shift_nxt = q_cmd.val;
          end
          if (pos_m2[3:1] == 3'b111) begin
            has_res = 1'b1;
            if (acc) begin
              rx_cnt_nxt = rx_cnt_cur + TXC_W'(1);
            end
          end
        end
        if (acc) begin
          rx_pos_nxt = pos_cur + RXP_W'(1);
        end
      end
    end
    q_push = acc && has_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_cnt_r   <= '0;
      rx_pos_r   <= '0;
      rx_shift_r <= '0;
      rx_cnt_r   <= '0;
    end else begin
      tx_cnt_r   <= tx_cnt_nxt;
      rx_pos_r   <= rx_pos_nxt;
      rx_shift_r <= rx_shift_nxt;
      rx_cnt_r   <= rx_cnt_nxt;
    end
  end

endmodule

// ===== src/sbpc_fifo.sv =====
// Short command queue between front end and back end.
`timescale 1ns / 1ps
module sbpc_fifo import sbpc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic pop,
  output logic rd_valid,
  output cmd_t rd_cmd
);

  cmd_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full     = cnt_r == FIFO_CW'(FIFO_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_cmd   = mem_r[rp_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_comb begin
    wp_nxt  = do_push ? wp_r + FIFO_AW'(1) : wp_r;
    rp_nxt  = do_pop ? rp_r + FIFO_AW'(1) : rp_r;
    cnt_nxt = cnt_r + FIFO_CW'(do_push) - FIFO_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== src/sbpc_back.sv =====
// Back end: expands commands into pin samples and received bytes.
`timescale 1ns / 1ps
module sbpc_back import sbpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [15:0] out_data,
  output logic        out_end
);

  logic        dec_r, dec_nxt, opn_r, opn_nxt, dat_r, dat_nxt, lst_r, lst_nxt;
  logic        tp_r, tp_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [7:0]  val_r, val_nxt;
  logic        ov_r, ov_nxt;
  logic        ok_r, ok_nxt, oe_r, oe_nxt;
  logic [15:0] od_r, od_nxt;

  logic        busy, advance, emit, fin, w_kind;
  logic [7:0]  w_pins, w_rx;

  assign busy    = dec_r || opn_r || dat_r || lst_r;
  assign advance = !ov_r || out_ready;
  assign emit    = busy && advance;

  always_comb begin
    w_kind = KIND_PIN;
    w_pins = '0;
    w_rx   = '0;
    fin    = 1'b0;
    if (dec_r) begin
      w_kind = KIND_BYTE;
      w_rx   = val_r;
      fin    = 1'b1;
    end else if (opn_r) begin
      fin = !dat_r && !lst_r;
    end else if (dat_r) begin
      w_pins = (val_r[~cnt_r[3:1]] ? cfg.mosi : 8'h00) | (cnt_r[0] ? cfg.clk : 8'h00);
      fin    = (cnt_r == 4'hF) && !lst_r;
    end else if (lst_r) begin
      w_pins = tp_r ? cfg.sel : (cfg.sel | cfg.clk);
      fin    = tp_r;
    end
  end

  always_comb begin
    dec_nxt = dec_r;
    opn_nxt = opn_r;
    dat_nxt = dat_r;
    lst_nxt = lst_r;
    tp_nxt  = tp_r;
    cnt_nxt = cnt_r;
    val_nxt = val_r;
    q_pop   = q_valid && (!busy || (emit && fin));
    if (emit) begin
      if (dec_r) begin
        dec_nxt = 1'b0;
      end else if (opn_r) begin
        opn_nxt = 1'b0;
      end else if (dat_r) begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'hF) begin
          dat_nxt = 1'b0;
        end
      end else if (lst_r) begin
        if (tp_r) begin
          lst_nxt = 1'b0;
        end else begin
          tp_nxt = 1'b1;
        end
      end
    end
    if (q_pop) begin
      dec_nxt = q_cmd.dec;
      opn_nxt = q_cmd.opn;
      dat_nxt = q_cmd.dat;
      lst_nxt = q_cmd.lst;
      val_nxt = q_cmd.val;
      tp_nxt  = 1'b0;
      cnt_nxt = '0;
    end
    ov_nxt = ov_r;
    ok_nxt = ok_r;
    oe_nxt = oe_r;
    od_nxt = od_r;
    if (advance) begin
      ov_nxt = busy;
      ok_nxt = w_kind;
      oe_nxt = fin;
      od_nxt = {w_rx, w_pins};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r <= 1'b0;
      opn_r <= 1'b0;
      dat_r <= 1'b0;
      lst_r <= 1'b0;
      tp_r  <= 1'b0;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      dec_r <= dec_nxt;
      opn_r <= opn_nxt;
      dat_r <= dat_nxt;
      lst_r <= lst_nxt;
      tp_r  <= tp_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    ok_r  <= ok_nxt;
    oe_r  <= oe_nxt;
    od_r  <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_kind  = ok_r;
  assign out_end   = oe_r;
  assign out_data  = od_r;

endmodule

// ===== src/sbpc_checker.sv =====
// Port-level checks of the codec, bound to the top level.
`timescale 1ns / 1ps
module sbpc_checker import sbpc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("output word changed while stalled");

  a_byte_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_BYTE) |-> out_tlast && (out_tdata[7:0] == 8'h00))
    else $error("received byte word malformed");

  a_pin_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_PIN) |-> out_tdata[15:8] == 8'h00)
    else $error("pin word carries byte bits");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind spi_bitbang_pattern_codec sbpc_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
